// File: sv/jsu_pkg.sv
package jsu_pkg;

    localparam int CountWidthDefault = 16;
    localparam int ByteWidth         = 8;
    localparam int WrittenWidth      = 16;
    localparam int CfgIndexWidth     = 3;
    localparam int CfgDataWidth      = 8;

    // configuration register indexes
    localparam logic [CfgIndexWidth-1:0] CfgUtf8Mode       = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CfgUtf8Substitute = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CfgFilterEnable   = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CfgBackspaceCode  = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CfgFormfeedCode   = 3'd4;
    localparam logic [CfgIndexWidth-1:0] CfgReturnCode     = 3'd5;
    localparam logic [CfgIndexWidth-1:0] CfgTabCode        = 3'd6;

    // utf-8 lead byte masks and patterns
    localparam logic [7:0] Lead2Mask = 8'b1110_0000;
    localparam logic [7:0] Lead2Code = 8'b1100_0000;
    localparam logic [7:0] Lead3Mask = 8'b1111_0000;
    localparam logic [7:0] Lead3Code = 8'b1110_0000;
    localparam logic [7:0] Lead4Mask = 8'b1111_1000;
    localparam logic [7:0] Lead4Code = 8'b1111_0000;

    // characters
    localparam logic [7:0] CharTilde     = 8'h7E;
    localparam logic [7:0] CharBackslash = 8'h5C;
    localparam logic [7:0] CharQuote     = 8'h22;
    localparam logic [7:0] CharNewline   = 8'h0A;
    localparam logic [7:0] CharAmp       = 8'h26;
    localparam logic [7:0] CharSpace     = 8'h20;
    localparam logic [7:0] LetterB       = 8'h62;
    localparam logic [7:0] LetterF       = 8'h66;
    localparam logic [7:0] LetterN       = 8'h6E;
    localparam logic [7:0] LetterR       = 8'h72;
    localparam logic [7:0] LetterT       = 8'h74;

    localparam logic [7:0] ResetSubstitute = 8'd63;
    localparam logic [7:0] ResetBackspace  = 8'd8;
    localparam logic [7:0] ResetFormfeed   = 8'd12;
    localparam logic [7:0] ResetReturn     = 8'd13;
    localparam logic [7:0] ResetTab        = 8'd9;

    typedef struct packed {
        logic                    char_valid;
        logic [ByteWidth-1:0]    out_char;
        logic                    end_of_string;
        logic [WrittenWidth-1:0] written_count;
    } result_t;

    function automatic logic is_printable(input logic [7:0] b);
        return (b >= CharSpace) && (b <= CharTilde) && (b != CharAmp);
    endfunction

endpackage

// File: sv/json_string_unescape.sv
// each accepted byte's result is registered into the output slot, or into the skid
// slot while m_tready is low; throughput: one byte per cycle while s_tready is high,
// a two-entry output stage lets input continue while a result waits for m_tready
// reset: synchronous active-low aresetn clears the escape and skip state, the
// character count, both output slots, and loads the register defaults
module json_string_unescape #(
    parameter int COUNT_WIDTH = jsu_pkg::CountWidthDefault
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [jsu_pkg::ByteWidth-1:0]      s_tdata,   // [7:0] in_byte
    input  logic                               s_tlast,   // in_last
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [23:0]                        m_tdata,   // [7:0] out_char, [23:8] written_count
    output logic                               m_tuser,   // [0] char_valid
    output logic                               m_tlast,   // end_of_string
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [jsu_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [jsu_pkg::CfgDataWidth-1:0]   cfg_data
);
    import jsu_pkg::*;

    logic       utf8_mode_reg;
    logic [7:0] utf8_substitute_reg;
    logic       filter_enable_reg;
    logic [7:0] backspace_code_reg;
    logic [7:0] formfeed_code_reg;
    logic [7:0] return_code_reg;
    logic [7:0] tab_code_reg;

    logic                   escape_pending_reg, escape_pending_next;
    logic [1:0]             skip_remaining_reg, skip_remaining_next;
    logic [COUNT_WIDTH-1:0] char_count_reg, char_count_next;

    logic                        valid_c;
    logic [7:0]                  char_c;
    logic [COUNT_WIDTH-1:0]      count_c;
    logic [COUNT_WIDTH+15:0]     count_ext;
    result_t                     result_c;

    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            utf8_mode_reg       <= 1'b0;
            utf8_substitute_reg <= ResetSubstitute;
            filter_enable_reg   <= 1'b0;
            backspace_code_reg  <= ResetBackspace;
            formfeed_code_reg   <= ResetFormfeed;
            return_code_reg     <= ResetReturn;
            tab_code_reg        <= ResetTab;
        end else if (cfg_valid) begin
            case (cfg_index)
                CfgUtf8Mode:       utf8_mode_reg       <= cfg_data[0];
                CfgUtf8Substitute: utf8_substitute_reg <= cfg_data;
                CfgFilterEnable:   filter_enable_reg   <= cfg_data[0];
                CfgBackspaceCode:  backspace_code_reg  <= cfg_data;
                CfgFormfeedCode:   formfeed_code_reg   <= cfg_data;
                CfgReturnCode:     return_code_reg     <= cfg_data;
                CfgTabCode:        tab_code_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // per-byte decode
    always_comb begin
        valid_c             = 1'b0;
        char_c              = '0;
        escape_pending_next = escape_pending_reg;
        skip_remaining_next = skip_remaining_reg;
        if (skip_remaining_reg != 2'd0) begin
            skip_remaining_next = skip_remaining_reg - 2'd1;
        end else if (escape_pending_reg) begin
            escape_pending_next = 1'b0;
            valid_c = 1'b1;
            case (s_tdata)
                LetterB:       char_c = backspace_code_reg;
                LetterF:       char_c = formfeed_code_reg;
                LetterR:       char_c = return_code_reg;
                LetterT:       char_c = tab_code_reg;
                LetterN:       char_c = CharNewline;
                CharQuote:     char_c = CharQuote;
                CharBackslash: char_c = CharBackslash;
                default:       valid_c = 1'b0;
            endcase
        end else if (utf8_mode_reg && s_tdata[7]) begin
            valid_c = 1'b1;
            if ((s_tdata & Lead2Mask) == Lead2Code) begin
                char_c = utf8_substitute_reg;
                skip_remaining_next = 2'd1;
            end else if ((s_tdata & Lead3Mask) == Lead3Code) begin
                char_c = utf8_substitute_reg;
                skip_remaining_next = 2'd2;
            end else if ((s_tdata & Lead4Mask) == Lead4Code) begin
                char_c = utf8_substitute_reg;
                skip_remaining_next = 2'd3;
            end else begin
                char_c = CharTilde;
            end
        end else if (s_tdata == CharBackslash) begin
            escape_pending_next = 1'b1;
        end else if (!filter_enable_reg || is_printable(s_tdata)) begin
            valid_c = 1'b1;
            char_c  = s_tdata;
        end

        count_c = char_count_reg;
        if (valid_c && (char_count_reg != {COUNT_WIDTH{1'b1}})) begin
            count_c = char_count_reg + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
        end
        count_ext = {16'd0, count_c};

        result_c.char_valid    = valid_c;
        result_c.out_char      = char_c;
        result_c.end_of_string = s_tlast;
        result_c.written_count = count_ext[15:0];

        char_count_next = count_c;
        if (s_tlast) begin
            escape_pending_next = 1'b0;
            skip_remaining_next = 2'd0;
            char_count_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_pending_reg <= 1'b0;
            skip_remaining_reg <= 2'd0;
            char_count_reg     <= '0;
        end else if (s_accept) begin
            escape_pending_reg <= escape_pending_next;
            skip_remaining_reg <= skip_remaining_next;
            char_count_reg     <= char_count_next;
        end
    end

    // output register with skid slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (s_accept) begin
            if (!out_valid_reg || m_tready) begin
                out_reg       <= result_c;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= result_c;
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.written_count, out_reg.out_char};
    assign m_tuser  = out_reg.char_valid;
    assign m_tlast  = out_reg.end_of_string;

endmodule

// File: dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int CountBits  = CountWidthDefault;
    localparam int StallLimit = 2000;
    localparam int ShowLimit  = 20;
    localparam logic [CfgIndexWidth-1:0] CfgNoReg = 3'd7;

    class unescape_scoreboard;
        logic                 utf8_on;
        logic                 filter_on;
        logic [7:0]           substitute;
        logic [7:0]           bs_code;
        logic [7:0]           ff_code;
        logic [7:0]           cr_code;
        logic [7:0]           tab_char;
        logic                 esc_pending;
        logic [1:0]           skip_left;
        logic [CountBits-1:0] char_total;
        result_t              expected_chars[$];
        int                   mismatches;

        function new();
            utf8_on     = 1'b0;
            filter_on   = 1'b0;
            substitute  = ResetSubstitute;
            bs_code     = ResetBackspace;
            ff_code     = ResetFormfeed;
            cr_code     = ResetReturn;
            tab_char    = ResetTab;
            esc_pending = 1'b0;
            skip_left   = '0;
            char_total  = '0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [7:0] val);
            case (idx)
                CfgUtf8Mode:       utf8_on = val[0];
                CfgUtf8Substitute: substitute = val;
                CfgFilterEnable:   filter_on = val[0];
                CfgBackspaceCode:  bs_code = val;
                CfgFormfeedCode:   ff_code = val;
                CfgReturnCode:     cr_code = val;
                CfgTabCode:        tab_char = val;
                default: ;
            endcase
        endfunction

        // decode one accepted byte and queue the character it should produce
        function void note_byte(logic [7:0] b, logic last);
            result_t r;
            r = '0;
            if (skip_left != 0) begin
                skip_left = skip_left - 2'd1;
            end else if (esc_pending) begin
                esc_pending = 1'b0;
                r.char_valid = 1'b1;
                case (b)
                    LetterB:       r.out_char = bs_code;
                    LetterF:       r.out_char = ff_code;
                    LetterR:       r.out_char = cr_code;
                    LetterT:       r.out_char = tab_char;
                    LetterN:       r.out_char = CharNewline;
                    CharQuote:     r.out_char = CharQuote;
                    CharBackslash: r.out_char = CharBackslash;
                    default:       r.char_valid = 1'b0;
                endcase
            end else if (utf8_on && b[7]) begin
                r.char_valid = 1'b1;
                r.out_char = substitute;
                if ((b & Lead2Mask) == Lead2Code) begin
                    skip_left = 2'd1;
                end else if ((b & Lead3Mask) == Lead3Code) begin
                    skip_left = 2'd2;
                end else if ((b & Lead4Mask) == Lead4Code) begin
                    skip_left = 2'd3;
                end else begin
                    r.out_char = CharTilde;
                end
            end else if (b == CharBackslash) begin
                esc_pending = 1'b1;
            end else if (!filter_on || (b >= CharSpace && b <= CharTilde && b != CharAmp)) begin
                r.char_valid = 1'b1;
                r.out_char = b;
            end
            if (r.char_valid && char_total != '1)
                char_total = char_total + 1'b1;
            r.end_of_string = last;
            r.written_count = WrittenWidth'(char_total);
            if (last) begin
                esc_pending = 1'b0;
                skip_left   = '0;
                char_total  = '0;
            end
            expected_chars.push_back(r);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= ShowLimit)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_char(logic cv, logic [7:0] ch, logic eos, logic [WrittenWidth-1:0] cnt);
            result_t want;
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending (char %02h count %0d)",
                                          ch, cnt));
            end else begin
                want = expected_chars.pop_front();
                if (cv !== want.char_valid)
                    report_mismatch($sformatf("char_valid %b, want %b", cv, want.char_valid));
                if (ch !== want.out_char)
                    report_mismatch($sformatf("out_char %02h, want %02h", ch, want.out_char));
                if (eos !== want.end_of_string)
                    report_mismatch($sformatf("end_of_string %b, want %b", eos,
                                              want.end_of_string));
                if (cnt !== want.written_count)
                    report_mismatch($sformatf("written_count %0d, want %0d", cnt,
                                              want.written_count));
            end
        endtask
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [ByteWidth-1:0]     s_tdata;   // [7:0] in_byte
    logic                     s_tlast;   // in_last
    logic                     m_tvalid;
    logic                     m_tready;
    logic [23:0]              m_tdata;   // [7:0] out_char, [23:8] written_count
    logic                     m_tuser;   // [0] char_valid
    logic                     m_tlast;   // end_of_string
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CfgDataWidth-1:0]  cfg_data;

    unescape_scoreboard sb;
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_request;
    int stall_cycles;
    int bytes_accepted;
    int chars_checked;
    int strings_sent;
    int reg_writes;

    json_string_unescape uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // transaction monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
                reg_writes++;
            end
            if (s_tvalid && s_tready) begin
                sb.note_byte(s_tdata, s_tlast);
                bytes_accepted++;
            end
            if (m_tvalid && m_tready) begin
                sb.check_char(m_tuser, m_tdata[7:0], m_tlast, m_tdata[23:8]);
                chars_checked++;
            end
        end
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= StallLimit) begin
            $display("watchdog: no transaction for %0d cycles", StallLimit);
            $display("[json_string_unescape] ERROR");
            $finish;
        end
    end

    // receiver back-pressure
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (60) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_escape(input logic [7:0] letter, input logic last);
        send_byte(CharBackslash, 1'b0);
        send_byte(letter, last);
    endtask

    task automatic program_reg(input logic [CfgIndexWidth-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (sb.expected_chars.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic apply_config(input logic utf8, input logic [7:0] subst, input logic filt,
                                input logic [7:0] bs, input logic [7:0] ff,
                                input logic [7:0] cr, input logic [7:0] tab);
        quiesce();
        program_reg(CfgUtf8Mode, {7'd0, utf8});
        program_reg(CfgUtf8Substitute, subst);
        program_reg(CfgFilterEnable, {7'd0, filt});
        program_reg(CfgBackspaceCode, bs);
        program_reg(CfgFormfeedCode, ff);
        program_reg(CfgReturnCode, cr);
        program_reg(CfgTabCode, tab);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic void add_token(ref logic [7:0] text[$]);
        int pick;
        int n_cont;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            text.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end else if (pick < 55) begin
            text.push_back(CharBackslash);
            case ($urandom_range(0, 7))
                0: text.push_back(LetterB);
                1: text.push_back(LetterF);
                2: text.push_back(LetterR);
                3: text.push_back(LetterT);
                4: text.push_back(LetterN);
                5: text.push_back(CharQuote);
                6: text.push_back(CharBackslash);
                default: text.push_back(8'($urandom));
            endcase
        end else if (pick < 75) begin
            n_cont = $urandom_range(1, 3);
            case (n_cont)
                1: text.push_back(Lead2Code | (8'($urandom) & ~Lead2Mask));
                2: text.push_back(Lead3Code | (8'($urandom) & ~Lead3Mask));
                default: text.push_back(Lead4Code | (8'($urandom) & ~Lead4Mask));
            endcase
            repeat (n_cont) text.push_back(8'h80 | (8'($urandom) & 8'h3F));
        end else if (pick < 90) begin
            text.push_back(8'($urandom));
        end else begin
            case ($urandom_range(0, 2))
                0: text.push_back(8'($urandom_range(0, 31)));
                1: text.push_back(CharAmp);
                default: text.push_back(8'h7F);
            endcase
        end
    endfunction

    // random strings, cut at a random length so escapes and sequences get truncated
    task automatic run_random(input int n_bytes);
        logic [7:0] text[$];
        int target;
        int sent;
        sent = 0;
        while (sent < n_bytes) begin
            target = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                 : $urandom_range(1, 24);
            text.delete();
            while (text.size() < target) add_token(text);
            while (text.size() > target) void'(text.pop_back());
            foreach (text[i]) send_byte(text[i], i == text.size() - 1);
            sent += text.size();
            strings_sent++;
        end
    endtask

    initial begin
        sb = new();
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_request = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // escapes and byte extremes with register defaults
        send_escape(LetterB, 1'b0);
        send_escape(LetterN, 1'b0);
        send_escape(CharQuote, 1'b0);
        send_escape(CharBackslash, 1'b0);
        send_escape(8'h78, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CharBackslash, 1'b1);
        strings_sent++;

        // utf-8 substitution and filter with extreme codes
        apply_config(1'b1, 8'h00, 1'b1, 8'hFF, 8'h00, 8'h80, 8'h7F);
        program_reg(CfgNoReg, 8'hFF);
        cfg_valid <= 1'b0;
        send_escape(LetterB, 1'b0);
        send_escape(LetterF, 1'b0);
        send_escape(LetterR, 1'b0);
        send_escape(LetterT, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(CharAmp, 1'b0);
        send_byte(8'hE2, 1'b1);
        strings_sent++;
        run_random(160);

        // stall the receiver while input keeps coming
        tx_idle_on = 1'b0;
        hold_request = 1'b1;
        run_random(60);
        tx_idle_on = 1'b1;

        apply_config(1'b0, 8'hFF, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
        run_random(220);

        apply_config(1'b1, 8'($urandom), 1'b0, 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
        run_random(220);

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        apply_config(1'b1, ResetSubstitute, 1'b0, 8'h00, 8'hFF, 8'hFF, 8'h00);
        run_random(220);

        quiesce();
        repeat (10) @(posedge aclk);
        $display("run covered %0d input bytes in %0d strings, %0d results, %0d register writes",
                 bytes_accepted, strings_sent, chars_checked, reg_writes);
        $display("escapes, utf-8 substitution, filtering and a long receiver stall, %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_chars.size() == 0) begin
            $display("[json_string_unescape] OK");
        end else begin
            $display("[json_string_unescape] ERROR");
        end
        $finish;
    end

endmodule
